// ===== hdl/adam_pkg.sv =====
// Shared types and constants for the bias-corrected Adam update block.
// Used by adam_iter_unit and adam_optimizer_update; depends on nothing.
package adam_pkg;

   // Register indexes of the control and status port.
   localparam logic [1:0] CSR_LEARN_RATE  = 2'd0;
   localparam logic [1:0] CSR_BETA_FIRST  = 2'd1;
   localparam logic [1:0] CSR_BETA_SECOND = 2'd2;
   localparam logic [1:0] CSR_EPSILON     = 2'd3;

   // Reset values of the registers (unsigned Q0.32).
   localparam logic [31:0] LEARN_RATE_RST  = 32'd4294967;
   localparam logic [31:0] BETA_FIRST_RST  = 32'd3865470566;
   localparam logic [31:0] BETA_SECOND_RST = 32'd4290672329;
   localparam logic [31:0] EPSILON_RST     = 32'd43;

   // Request operation codes.
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Fixed-point constants.
   localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
   localparam logic [31:0] HALF_Q32  = 32'h8000_0000;
   localparam logic [47:0] MAX48     = 48'hFFFF_FFFF_FFFF;
   localparam logic [30:0] MAX_Q1616 = 31'h7FFF_FFFF;

   // Widths of the shared iterative unit.
   localparam int WORK_W = 80;
   localparam int DSR_W  = 41;
   localparam int ROOT_W = 32;
   localparam int CNT_W  = 7;

   // Iteration counts for each kind of pass.
   localparam logic [CNT_W-1:0] ITER_DIV64 = 7'd64;
   localparam logic [CNT_W-1:0] ITER_DIV80 = 7'd80;
   localparam logic [CNT_W-1:0] ITER_SQRT  = 7'd32;

   // Control sent from the sequencer to the iterative unit.
   typedef struct packed {
      logic             start;
      logic             is_sqrt;
      logic [CNT_W-1:0] count;
   } iter_ctrl_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POW1,
      ST_POW2,
      ST_POWW,
      ST_MOM1,
      ST_MOM2,
      ST_MOM3,
      ST_SQG,
      ST_VHI1,
      ST_VHI2,
      ST_VLO1,
      ST_VLO2,
      ST_D1GO,
      ST_D1W,
      ST_D2GO,
      ST_D2W,
      ST_SQGO,
      ST_SQW,
      ST_MULQ,
      ST_D3GO,
      ST_D3W,
      ST_FIN
   } state_type;

endpackage

// ===== hdl/adam_iter_unit.sv =====
// Shared bit-serial divider and square root unit, one bit per cycle.
// Depends on adam_pkg for the control struct and widths.
module adam_iter_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  adam_pkg::iter_ctrl_type       ctrl,
   input  logic [adam_pkg::WORK_W-1:0]   dividend,
   input  logic [adam_pkg::DSR_W-1:0]    divisor,
   output logic                          done,
   output logic [adam_pkg::WORK_W-1:0]   quotient,
   output logic [adam_pkg::ROOT_W-1:0]   root
);

   logic                          busy_ff;
   logic                          done_ff;
   logic                          is_sqrt_ff;
   logic [adam_pkg::CNT_W-1:0]    cnt_ff;
   logic [adam_pkg::WORK_W-1:0]   work_ff;
   logic [adam_pkg::DSR_W:0]      rem_ff;
   logic [adam_pkg::DSR_W-1:0]    dsr_ff;
   logic [adam_pkg::ROOT_W-1:0]   root_ff;

   logic [adam_pkg::DSR_W:0]      partial;
   logic [adam_pkg::DSR_W:0]      subtrahend;
   logic [adam_pkg::DSR_W+1:0]    diff;
   logic                          fits;

   // One restoring step: bring down one bit (divide) or two bits (root).
   always_comb begin
      if (is_sqrt_ff) begin
         partial    = {rem_ff[adam_pkg::DSR_W-2:0], work_ff[adam_pkg::WORK_W-1 -: 2]};
         subtrahend = {8'd0, root_ff, 2'b01};
      end else begin
         partial    = {rem_ff[adam_pkg::DSR_W-1:0], work_ff[adam_pkg::WORK_W-1]};
         subtrahend = {1'b0, dsr_ff};
      end
      diff = {1'b0, partial} - {1'b0, subtrahend};
      fits = !diff[adam_pkg::DSR_W+1];
   end

   // Iteration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff    <= 1'b1;
            cnt_ff     <= ctrl.count;
            is_sqrt_ff <= ctrl.is_sqrt;
            work_ff    <= dividend;
            dsr_ff     <= divisor;
            rem_ff     <= '0;
            root_ff    <= '0;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[adam_pkg::DSR_W:0] : partial;
            if (is_sqrt_ff) begin
               work_ff <= {work_ff[adam_pkg::WORK_W-3:0], 2'b00};
               root_ff <= {root_ff[adam_pkg::ROOT_W-2:0], fits};
            end else begin
               work_ff <= {work_ff[adam_pkg::WORK_W-2:0], fits};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == adam_pkg::CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = work_ff;
   assign root     = root_ff;

   // A new pass is started only when the unit is free.
   assert property (@(posedge clock) disable iff (reset) ctrl.start |-> !busy_ff)
      else $error("iterative unit started while busy");

   // The last iteration is followed by the done pulse.
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !ctrl.start && cnt_ff == adam_pkg::CNT_W'(1)) |=> (done_ff && !busy_ff))
      else $error("iterative unit missed its done pulse");

   // The done pulse never overlaps a running pass.
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("done raised while busy");

endmodule

// ===== hdl/adam_optimizer_update.sv =====
// Top level of the bias-corrected Adam update: sequencer, moment memories,
// shared multiplier and result register. Depends on adam_pkg and adam_iter_unit.
//
//   Channel   Direction  Handshake              Carries
//   req_      in         req_valid/req_ready    op, param_in, grad, last_of_step
//   rsp_      out        rsp_valid/rsp_ready    param_out, step_done
//   csr_      in         csr_valid/csr_ready    register index, write data
//
// An update request is worked through in full before the next one is accepted. The
// first element of a step also advances the powers; a zero denominator skips the
// last division. Three passes of the shared bit-serial divider (64, 80 and 64
// iterations) and a 32-iteration square root make up most of that work.
// After reset, and after each clear request, a clearing pass zeroes all NUM_PARAMS
// entries of the moment memories; no request is accepted meanwhile.
// Register writes are taken in any cycle. A result held in the output register
// lets the next request start; only the final write of that request waits.
module adam_optimizer_update #(
   parameter int NUM_PARAMS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic signed [31:0] req_param_in,
   input  logic signed [31:0] req_grad,
   input  logic               req_last_of_step,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_param_out,
   output logic               rsp_step_done,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int IDX_W = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARAMS - 1);

   // Configuration registers.
   logic [31:0] learn_rate_ff, beta_first_ff, beta_second_ff, epsilon_ff;

   // Sequencer and item state.
   adam_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [32:0]         pow1_ff, pow1_in, pow2_ff, pow2_in;
   logic signed [31:0]  p_ff, g_ff;
   logic                last_ff;
   logic signed [67:0]  acc_ff, acc_in;
   logic signed [67:0]  acc2_ff, acc2_in;
   logic signed [31:0]  m_new_ff, m_new_in;
   logic [47:0]         g2_ff, g2_in;
   logic [47:0]         v_new_ff, v_new_in;
   logic [30:0]         q1_ff, q1_in;
   logic [47:0]         vhat_ff, vhat_in;
   logic [40:0]         den_ff, den_in;
   logic [32:0]         qstep_ff, qstep_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_param_out_ff, rsp_param_out_in;
   logic                rsp_step_done_ff, rsp_step_done_in;

   // Shared multiplier.
   logic signed [33:0]  mul_a, mul_b;
   logic signed [67:0]  prod_ff;

   // Moment memories.
   logic signed [31:0]  m_mem [NUM_PARAMS];
   logic [47:0]         v_mem [NUM_PARAMS];
   logic signed [31:0]  m_rd_ff;
   logic [47:0]         v_rd_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_addr;
   logic signed [31:0]  mem_m_wd;
   logic [47:0]         mem_v_wd;

   // Iterative unit.
   adam_pkg::iter_ctrl_type     iter_ctrl;
   logic [adam_pkg::WORK_W-1:0] iter_dividend;
   logic [adam_pkg::DSR_W-1:0]  iter_divisor;
   logic                        iter_done;
   logic [adam_pkg::WORK_W-1:0] iter_quo;
   logic [adam_pkg::ROOT_W-1:0] iter_root;

   // Derived values.
   logic        req_take;
   logic [32:0] bc1, bc2, c1, c2;
   logic [65:0] pow_rnd;
   logic signed [67:0] m_sum;
   logic [31:0] gmag, mmag;
   logic [67:0] lo_sum;
   logic [49:0] v_sum;
   logic [63:0] d1, d3;
   logic signed [33:0] res;
   logic        item_done;

   adam_iter_unit u_iter (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (iter_ctrl),
      .dividend (iter_dividend),
      .divisor  (iter_divisor),
      .done     (iter_done),
      .quotient (iter_quo),
      .root     (iter_root)
   );

   // Configuration writes.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff  <= adam_pkg::LEARN_RATE_RST;
         beta_first_ff  <= adam_pkg::BETA_FIRST_RST;
         beta_second_ff <= adam_pkg::BETA_SECOND_RST;
         epsilon_ff     <= adam_pkg::EPSILON_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            adam_pkg::CSR_LEARN_RATE:  learn_rate_ff  <= csr_data;
            adam_pkg::CSR_BETA_FIRST:  beta_first_ff  <= csr_data;
            adam_pkg::CSR_BETA_SECOND: beta_second_ff <= csr_data;
            adam_pkg::CSR_EPSILON:     epsilon_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Bias corrections and moment helpers.
   always_comb begin
      bc1     = (pow1_ff == adam_pkg::ONE_Q32) ? 33'd1 : adam_pkg::ONE_Q32 - pow1_ff;
      bc2     = (pow2_ff == adam_pkg::ONE_Q32) ? 33'd1 : adam_pkg::ONE_Q32 - pow2_ff;
      c1      = adam_pkg::ONE_Q32 - {1'b0, beta_first_ff};
      c2      = adam_pkg::ONE_Q32 - {1'b0, beta_second_ff};
      pow_rnd = {1'b0, prod_ff[64:0]} + 66'(adam_pkg::HALF_Q32);
      m_sum   = acc_ff + prod_ff + 68'(adam_pkg::HALF_Q32);
      gmag    = g_ff[31] ? (~g_ff + 32'd1) : g_ff;
      mmag    = m_new_ff[31] ? (~m_new_ff + 32'd1) : m_new_ff;
      lo_sum  = acc2_ff + prod_ff + 68'(adam_pkg::HALF_Q32);
      v_sum   = acc_ff[49:0] + {14'd0, lo_sum[67:32]};
      d1      = {mmag, 32'd0} + 64'(bc1[32:1]);
      d3      = prod_ff[63:0] + 64'(den_ff[40:1]);
      res     = m_new_ff[31] ? ({{2{p_ff[31]}}, p_ff} + {1'b0, qstep_ff})
                             : ({{2{p_ff[31]}}, p_ff} - {1'b0, qstep_ff});
      item_done = last_ff || (idx_ff == LAST_IDX);
   end

   assign req_ready = (state_ff == adam_pkg::ST_IDLE);
   assign req_take  = req_valid && req_ready;

   // Sequencer: next state, multiplier operands and datapath updates.
   always_comb begin
      state_in         = state_ff;
      clr_addr_in      = clr_addr_ff;
      idx_in           = idx_ff;
      pow1_in          = pow1_ff;
      pow2_in          = pow2_ff;
      acc_in           = acc_ff;
      acc2_in          = acc2_ff;
      m_new_in         = m_new_ff;
      g2_in            = g2_ff;
      v_new_in         = v_new_ff;
      q1_in            = q1_ff;
      vhat_in          = vhat_ff;
      den_in           = den_ff;
      qstep_in         = qstep_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_param_out_in = rsp_param_out_ff;
      rsp_step_done_in = rsp_step_done_ff;
      mul_a            = '0;
      mul_b            = '0;
      mem_we           = 1'b0;
      mem_addr         = idx_ff;
      mem_m_wd         = m_new_ff;
      mem_v_wd         = v_new_ff;
      iter_ctrl        = '0;
      iter_dividend    = '0;
      iter_divisor     = '0;

      unique case (state_ff)
         adam_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_addr    = clr_addr_ff;
            mem_m_wd    = '0;
            mem_v_wd    = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_IDX) begin
               clr_addr_in = '0;
               state_in    = adam_pkg::ST_IDLE;
            end
         end
         adam_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_op == adam_pkg::OP_CLEAR) begin
                  idx_in   = '0;
                  pow1_in  = adam_pkg::ONE_Q32;
                  pow2_in  = adam_pkg::ONE_Q32;
                  state_in = adam_pkg::ST_CLEAR;
               end else if (idx_ff == '0) begin
                  state_in = adam_pkg::ST_POW1;
               end else begin
                  state_in = adam_pkg::ST_MOM1;
               end
            end
         end
         // Advance the running powers at the first element of a step.
         adam_pkg::ST_POW1: begin
            mul_a    = {1'b0, pow1_ff};
            mul_b    = {2'b00, beta_first_ff};
            state_in = adam_pkg::ST_POW2;
         end
         adam_pkg::ST_POW2: begin
            pow1_in  = pow_rnd[64:32];
            mul_a    = {1'b0, pow2_ff};
            mul_b    = {2'b00, beta_second_ff};
            state_in = adam_pkg::ST_POWW;
         end
         adam_pkg::ST_POWW: begin
            pow2_in  = pow_rnd[64:32];
            state_in = adam_pkg::ST_MOM1;
         end
         // First moment: b1*m + (1-b1)*g, rounded.
         adam_pkg::ST_MOM1: begin
            mul_a    = {2'b00, beta_first_ff};
            mul_b    = {{2{m_rd_ff[31]}}, m_rd_ff};
            state_in = adam_pkg::ST_MOM2;
         end
         adam_pkg::ST_MOM2: begin
            acc_in   = prod_ff;
            mul_a    = {1'b0, c1};
            mul_b    = {{2{g_ff[31]}}, g_ff};
            state_in = adam_pkg::ST_MOM3;
         end
         adam_pkg::ST_MOM3: begin
            m_new_in = m_sum[63:32];
            mul_a    = {2'b00, gmag};
            mul_b    = {2'b00, gmag};
            state_in = adam_pkg::ST_SQG;
         end
         // Second moment, split into high and low halves of v and g*g.
         adam_pkg::ST_SQG: begin
            g2_in    = (|prod_ff[67:48]) ? adam_pkg::MAX48 : prod_ff[47:0];
            mul_a    = {2'b00, beta_second_ff};
            mul_b    = {18'd0, v_rd_ff[47:32]};
            state_in = adam_pkg::ST_VHI1;
         end
         adam_pkg::ST_VHI1: begin
            acc_in   = prod_ff;
            mul_a    = {1'b0, c2};
            mul_b    = {18'd0, g2_ff[47:32]};
            state_in = adam_pkg::ST_VHI2;
         end
         adam_pkg::ST_VHI2: begin
            acc_in   = acc_ff + prod_ff;
            mul_a    = {2'b00, beta_second_ff};
            mul_b    = {2'b00, v_rd_ff[31:0]};
            state_in = adam_pkg::ST_VLO1;
         end
         adam_pkg::ST_VLO1: begin
            acc2_in  = prod_ff;
            mul_a    = {1'b0, c2};
            mul_b    = {2'b00, g2_ff[31:0]};
            state_in = adam_pkg::ST_VLO2;
         end
         adam_pkg::ST_VLO2: begin
            v_new_in = (|v_sum[49:48]) ? adam_pkg::MAX48 : v_sum[47:0];
            state_in = adam_pkg::ST_D1GO;
         end
         // Bias-corrected first moment magnitude.
         adam_pkg::ST_D1GO: begin
            iter_ctrl     = '{start: 1'b1, is_sqrt: 1'b0, count: adam_pkg::ITER_DIV64};
            iter_dividend = {d1, 16'd0};
            iter_divisor  = {8'd0, bc1};
            state_in      = adam_pkg::ST_D1W;
         end
         adam_pkg::ST_D1W: begin
            if (iter_done) begin
               q1_in    = (|iter_quo[79:31]) ? adam_pkg::MAX_Q1616 : iter_quo[30:0];
               state_in = adam_pkg::ST_D2GO;
            end
         end
         // Bias-corrected second moment.
         adam_pkg::ST_D2GO: begin
            iter_ctrl     = '{start: 1'b1, is_sqrt: 1'b0, count: adam_pkg::ITER_DIV80};
            iter_dividend = {v_new_ff, 32'd0} + 80'(bc2[32:1]);
            iter_divisor  = {8'd0, bc2};
            state_in      = adam_pkg::ST_D2W;
         end
         adam_pkg::ST_D2W: begin
            if (iter_done) begin
               vhat_in  = (|iter_quo[79:48]) ? adam_pkg::MAX48 : iter_quo[47:0];
               state_in = adam_pkg::ST_SQGO;
            end
         end
         // Square root of the second moment, then the guarded denominator.
         adam_pkg::ST_SQGO: begin
            iter_ctrl     = '{start: 1'b1, is_sqrt: 1'b1, count: adam_pkg::ITER_SQRT};
            iter_dividend = {vhat_ff, 32'd0};
            state_in      = adam_pkg::ST_SQW;
         end
         adam_pkg::ST_SQW: begin
            if (iter_done) begin
               den_in   = {1'b0, iter_root, 8'd0} + {9'd0, epsilon_ff};
               state_in = adam_pkg::ST_MULQ;
            end
         end
         adam_pkg::ST_MULQ: begin
            mul_a    = {2'b00, learn_rate_ff};
            mul_b    = {3'b000, q1_ff};
            state_in = adam_pkg::ST_D3GO;
         end
         // Step length, skipped when the denominator is zero.
         adam_pkg::ST_D3GO: begin
            if (den_ff == '0) begin
               qstep_in = '0;
               state_in = adam_pkg::ST_FIN;
            end else begin
               iter_ctrl     = '{start: 1'b1, is_sqrt: 1'b0, count: adam_pkg::ITER_DIV64};
               iter_dividend = {d3, 16'd0};
               iter_divisor  = den_ff;
               state_in      = adam_pkg::ST_D3W;
            end
         end
         adam_pkg::ST_D3W: begin
            if (iter_done) begin
               if ((|iter_quo[79:33]) || (iter_quo[32] && (|iter_quo[31:0]))) begin
                  qstep_in = adam_pkg::ONE_Q32;
               end else begin
                  qstep_in = iter_quo[32:0];
               end
               state_in = adam_pkg::ST_FIN;
            end
         end
         // Write back moments and hand the result to the output register.
         adam_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               mem_we       = 1'b1;
               rsp_valid_in = 1'b1;
               if (res[33:31] == 3'b000 || res[33:31] == 3'b111) begin
                  rsp_param_out_in = res[31:0];
               end else if (res[33]) begin
                  rsp_param_out_in = 32'sh8000_0000;
               end else begin
                  rsp_param_out_in = 32'sh7FFF_FFFF;
               end
               rsp_step_done_in = item_done;
               idx_in           = item_done ? '0 : idx_ff + 1'b1;
               state_in         = adam_pkg::ST_IDLE;
            end
         end
         default: state_in = adam_pkg::ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= adam_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         idx_ff       <= '0;
         pow1_ff      <= adam_pkg::ONE_Q32;
         pow2_ff      <= adam_pkg::ONE_Q32;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         idx_ff       <= idx_in;
         pow1_ff      <= pow1_in;
         pow2_ff      <= pow2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         p_ff    <= req_param_in;
         g_ff    <= req_grad;
         last_ff <= req_last_of_step;
      end
      prod_ff          <= mul_a * mul_b;
      acc_ff           <= acc_in;
      acc2_ff          <= acc2_in;
      m_new_ff         <= m_new_in;
      g2_ff            <= g2_in;
      v_new_ff         <= v_new_in;
      q1_ff            <= q1_in;
      vhat_ff          <= vhat_in;
      den_ff           <= den_in;
      qstep_ff         <= qstep_in;
      rsp_param_out_ff <= rsp_param_out_in;
      rsp_step_done_ff <= rsp_step_done_in;
   end

   // Moment memories: one write port, registered read at the current element.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         m_mem[mem_addr] <= mem_m_wd;
         v_mem[mem_addr] <= mem_v_wd;
      end
      m_rd_ff <= m_mem[idx_ff];
      v_rd_ff <= v_mem[idx_ff];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_param_out = rsp_param_out_ff;
   assign rsp_step_done = rsp_step_done_ff;

   // A clear request always leads into the clearing pass.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_op == adam_pkg::OP_CLEAR) |=> (state_ff == adam_pkg::ST_CLEAR))
      else $error("clear request did not start the clearing pass");

   // A new result appears only out of the write-back state.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_ready)) |-> (state_ff == adam_pkg::ST_FIN))
      else $error("result loaded outside write-back");

   // The element index returns to zero whenever a result ends the step.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == adam_pkg::ST_FIN && mem_we && item_done) |=> (idx_ff == '0))
      else $error("element index not reset at end of step");

endmodule

// ===== sim/adam_optimizer_update_test.sv =====
// Self-checking testbench for adam_optimizer_update: random and directed Adam requests
// checked against a fixed-point predictor held in a small scoreboard class.
// Depends on adam_pkg and the adam_optimizer_update RTL.
`timescale 1ns / 1ps

module adam_optimizer_update_test;

   localparam int NPARAM      = 1024;
   localparam int RESET_CYC   = 12;
   localparam int DRAIN_CYC   = 1500;
   localparam int LIMIT_CYC   = 5000000;
   localparam int HOLD_CYC    = 3000;
   localparam int HOLD_AT_RSP = 200;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_op = adam_pkg::OP_UPDATE;
   logic signed [31:0] req_param_in = '0;
   logic signed [31:0] req_grad = '0;
   logic               req_last_of_step = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_param_out;
   logic               rsp_step_done;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = adam_pkg::CSR_LEARN_RATE;
   logic [31:0]        csr_data = '0;

   int unsigned cycle_count = 0;
   int unsigned rsp_count = 0;
   bit          no_gaps = 1'b0;

   adam_optimizer_update #(.NUM_PARAMS(NPARAM)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_param_in(req_param_in), .req_grad(req_grad),
      .req_last_of_step(req_last_of_step),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_param_out(rsp_param_out), .rsp_step_done(rsp_step_done),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   typedef struct {
      logic [31:0] param_out;
      logic        step_done;
   } update_result_type;

   // Floor square root of a 64-bit value, one result bit per pass.
   function automatic logic [63:0] floor_root(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] cand;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         cand = r | (64'd1 << i);
         if (cand * cand <= x) r = cand;
      end
      return r;
   endfunction

   // Adam state, register copies and the queue of updated parameters still to come.
   class adam_board;
      logic [31:0]        lr, b1, b2, eps;
      logic signed [31:0] m_mem[NPARAM];
      logic [47:0]        v_mem[NPARAM];
      int unsigned        elem_idx;
      logic [32:0]        pow1, pow2;
      update_result_type  pending_q[$];
      int unsigned        errors;

      function void clear_state();
         for (int i = 0; i < NPARAM; i++) begin
            m_mem[i] = '0;
            v_mem[i] = '0;
         end
         elem_idx = 0;
         pow1 = adam_pkg::ONE_Q32;
         pow2 = adam_pkg::ONE_Q32;
      endfunction

      function void init();
         lr = adam_pkg::LEARN_RATE_RST;
         b1 = adam_pkg::BETA_FIRST_RST;
         b2 = adam_pkg::BETA_SECOND_RST;
         eps = adam_pkg::EPSILON_RST;
         errors = 0;
         clear_state();
      endfunction

      function void set_reg(input logic [1:0] idx, input logic [31:0] val);
         case (idx)
            adam_pkg::CSR_LEARN_RATE:  lr = val;
            adam_pkg::CSR_BETA_FIRST:  b1 = val;
            adam_pkg::CSR_BETA_SECOND: b2 = val;
            default:                   eps = val;
         endcase
      endfunction

      task report(input string what);
         $display("ERROR at cycle %0d: %s", cycle_count, what);
         errors++;
      endtask

      // Works out the updated parameter for an accepted request.
      function void note_request(input logic op, input logic signed [31:0] p,
                                 input logic signed [31:0] g, input logic last);
         logic signed [95:0] sum, ta, tb;
         logic signed [63:0] pp, gg, mh, res;
         logic [63:0]        tmp, mag, g2, bc1, bc2, c1, c2, vv, hi, lo, q, vhat, ip, den;
         logic [95:0]        frac;
         bit                 neg, done;
         int unsigned        k;
         update_result_type  r;
         if (op == adam_pkg::OP_CLEAR) begin
            clear_state();
            return;
         end
         k = (elem_idx >= NPARAM) ? 0 : elem_idx;
         pp = p;
         gg = g;
         // The bias powers advance at the first element of a step.
         if (k == 0) begin
            tmp = 64'(pow1) * 64'(b1) + 64'(adam_pkg::HALF_Q32);
            pow1 = 33'(tmp >> 32);
            tmp = 64'(pow2) * 64'(b2) + 64'(adam_pkg::HALF_Q32);
            pow2 = 33'(tmp >> 32);
         end
         bc1 = 64'(adam_pkg::ONE_Q32) - 64'(pow1);
         bc2 = 64'(adam_pkg::ONE_Q32) - 64'(pow2);
         if (bc1 == 0) bc1 = 1;
         if (bc2 == 0) bc2 = 1;
         // First moment, rounded and floored to Q16.16.
         c1 = 64'(adam_pkg::ONE_Q32) - 64'(b1);
         ta = $signed({64'd0, b1});
         tb = m_mem[k];
         sum = ta * tb;
         ta = $signed({32'd0, c1});
         tb = gg;
         sum = sum + ta * tb + $signed(96'h8000_0000);
         m_mem[k] = sum[63:32];
         // Second moment from the saturated squared gradient.
         mag = (gg < 0) ? -gg : gg;
         g2 = mag * mag;
         if (g2 > 64'(adam_pkg::MAX48)) g2 = 64'(adam_pkg::MAX48);
         c2 = 64'(adam_pkg::ONE_Q32) - 64'(b2);
         vv = 64'(v_mem[k]);
         hi = 64'(b2) * (vv >> 32) + c2 * (g2 >> 32);
         lo = 64'(b2) * {32'd0, vv[31:0]} + c2 * {32'd0, g2[31:0]};
         vv = hi + ((lo + 64'(adam_pkg::HALF_Q32)) >> 32);
         if (vv > 64'(adam_pkg::MAX48)) vv = 64'(adam_pkg::MAX48);
         v_mem[k] = vv[47:0];
         // Bias-corrected first moment magnitude.
         mh = m_mem[k];
         neg = mh < 0;
         mag = neg ? -mh : mh;
         q = ((mag << 32) + (bc1 >> 1)) / bc1;
         if (q > 64'(adam_pkg::MAX_Q1616)) q = 64'(adam_pkg::MAX_Q1616);
         // Bias-corrected second moment.
         ip = vv / bc2;
         if (ip >= 64'h1_0000) begin
            vhat = 64'(adam_pkg::MAX48);
         end else begin
            frac = (96'(vv % bc2) << 32) + 96'(bc2 >> 1);
            vhat = (ip << 32) + 64'(frac / 96'(bc2));
            if (vhat > 64'(adam_pkg::MAX48)) vhat = 64'(adam_pkg::MAX48);
         end
         den = (floor_root(vhat << 16) << 8) + 64'(eps);
         if (den == 0) begin
            q = 0;
         end else begin
            q = (64'(lr) * q + (den >> 1)) / den;
            if (q > 64'(adam_pkg::ONE_Q32)) q = 64'(adam_pkg::ONE_Q32);
         end
         res = neg ? pp + $signed(q) : pp - $signed(q);
         if (res > 64'sd2147483647) res = 64'sd2147483647;
         if (res < -64'sd2147483648) res = -64'sd2147483648;
         done = last || (k == NPARAM - 1);
         elem_idx = done ? 0 : k + 1;
         r.param_out = res[31:0];
         r.step_done = done;
         pending_q.push_back(r);
      endfunction

      task check_result(input logic [31:0] pout, input logic done);
         update_result_type e;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected response param_out=%h", pout));
         end else begin
            e = pending_q.pop_front();
            if (pout !== e.param_out)
               report($sformatf("param_out %h, expected %h", pout, e.param_out));
            if (done !== e.step_done)
               report($sformatf("step_done %b, expected %b", done, e.step_done));
         end
      endtask
   endclass

   adam_board board = new();

   // Gap length: mostly none, some short, a few long.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [31:0] pick_grad();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 32'($signed($urandom_range(0, 262143)) - 131072);
      if (r < 60) return $urandom();
      if (r < 72) return {$urandom_range(0, 1) ? 8'hFE : 8'h01, 24'($urandom())};
      if (r < 82) return '0;
      if (r < 90) return 32'h8000_0000;
      return 32'h7FFF_FFFF;
   endfunction

   function automatic logic [31:0] pick_param();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom();
      if (r < 90) return 32'h7FFF_FFFF;
      return 32'h8000_0000;
   endfunction

   // Offers one request and holds it until accepted; called at a falling edge.
   task automatic send_req(input logic op, input logic [31:0] p, input logic [31:0] g,
                           input logic last);
      int gap;
      req_op <= op;
      req_param_in <= p;
      req_grad <= g;
      req_last_of_step <= last;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      board.note_request(op, p, g, last);
      @(negedge clock);
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic update(input logic [31:0] p, input logic [31:0] g, input logic last);
      send_req(adam_pkg::OP_UPDATE, p, g, last);
   endtask

   task automatic clear_all();
      send_req(adam_pkg::OP_CLEAR, $urandom(), $urandom(), 1'($urandom()));
   endtask

   // Waits until every result has come and any clearing pass is over.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (board.pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYC) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_regs(input logic [31:0] lr, input logic [31:0] b1,
                           input logic [31:0] b2, input logic [31:0] eps);
      wait_drained();
      write_reg(adam_pkg::CSR_LEARN_RATE, lr);
      write_reg(adam_pkg::CSR_BETA_FIRST, b1);
      write_reg(adam_pkg::CSR_BETA_SECOND, b2);
      write_reg(adam_pkg::CSR_EPSILON, eps);
   endtask

   function automatic logic [31:0] pick_beta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 32'hF000_0000 | 32'($urandom_range(0, 32'h0FFF_FFFF));
      if (r < 70) return $urandom();
      if (r < 85) return 32'hFFFF_FFFF;
      return '0;
   endfunction

   function automatic logic [31:0] pick_eps();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom_range(0, 1000);
      if (r < 60) return '0;
      if (r < 80) return $urandom();
      return 32'hFFFF_FFFF;
   endfunction

   // Mostly whole steps with random content, plus clears and loose elements.
   task automatic random_phase(input int n_items);
      int sent, len, r;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            len = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            for (int i = 0; i < len; i++) update(pick_param(), pick_grad(), i == len - 1);
            sent += len;
         end else if (r < 88) begin
            clear_all();
            sent++;
         end else begin
            update(pick_param(), pick_grad(), 1'($urandom()));
            sent++;
         end
      end
   endtask

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYC) begin
         $display("adam_optimizer_update: mismatch");
         $finish;
      end
   end

   // Result sampling at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result(rsp_param_out, rsp_step_done);
         rsp_count <= rsp_count + 1;
      end
   end

   // Receiver: random stalls, and one long hold so the block backs up.
   initial begin
      int stall_left;
      bit held;
      stall_left = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && rsp_count >= HOLD_AT_RSP) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYC) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < 20) stall_left = idle_len();
         end
      end
   end

   // Main sequence.
   initial begin
      board.init();
      repeat (RESET_CYC) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset settings, field extremes, a short step.
      update(32'h0001_0000, 32'h0000_8000, 1'b0);
      update(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      update(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      update(32'h0, 32'h0, 1'b1);
      update(32'hFFFF_FFFF, 32'h0100_0000, 1'b1);
      update(32'h1234_5678, 32'hFF00_0000, 1'b1);
      clear_all();
      update(32'h0000_0000, 32'h0000_0001, 1'b1);

      // Zero denominator: no epsilon and a zero gradient after a clear.
      set_regs(adam_pkg::LEARN_RATE_RST, adam_pkg::BETA_FIRST_RST,
               adam_pkg::BETA_SECOND_RST, 32'h0);
      clear_all();
      update(32'h0012_3400, 32'h0, 1'b1);
      update(32'h8000_0000, 32'h0, 1'b1);

      // Extreme registers: no decay, full learning rate, large epsilon.
      set_regs(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
      update(32'h7FFF_0000, 32'h8000_0000, 1'b1);
      update(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      set_regs(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
      update(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      update(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1);
      update(32'h0, 32'h7FFF_FFFF, 1'b0);
      update(32'h0, 32'h8000_0000, 1'b1);
      clear_all();
      update(32'h0, 32'h0001_0000, 1'b1);

      // Random phases, each with its own register setting.
      for (int ph = 0; ph < 6; ph++) begin
         no_gaps = (ph == 2);
         if (ph == 0)
            set_regs(adam_pkg::LEARN_RATE_RST, adam_pkg::BETA_FIRST_RST,
                     adam_pkg::BETA_SECOND_RST, adam_pkg::EPSILON_RST);
         else
            set_regs($urandom(), pick_beta(), pick_beta(), pick_eps());
         random_phase(20);
         if (ph == 3) begin
            // A step longer than the moment memory wraps at the last element.
            wait_drained();
            no_gaps = 1'b1;
            clear_all();
            for (int i = 0; i < NPARAM + 6; i++) update(pick_param(), pick_grad(), 1'b0);
            update(pick_param(), pick_grad(), 1'b1);
            no_gaps = 1'b0;
         end
      end

      wait_drained();
      if (board.errors == 0) begin
         $display("adam_optimizer_update: match");
      end else begin
         $display("adam_optimizer_update: mismatch");
      end
      $finish;
   end

endmodule
